// File: hdl/lfo_pkg.sv
// ----------------------------------------------------------------------------
// lfo_pkg
// Types and constants shared by the multi-waveform LFO modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfo_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SELECT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RETRIG      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_PHASE = 8'd3;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_TRIGGER = 1'b1;

  localparam logic [2:0] WAVE_SINE      = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE  = 3'd1;
  localparam logic [2:0] WAVE_SAW_UP    = 3'd2;
  localparam logic [2:0] WAVE_SAW_DOWN  = 3'd3;
  localparam logic [2:0] WAVE_SQUARE    = 3'd4;
  localparam logic [2:0] WAVE_RANDOM    = 3'd5;
  localparam logic [2:0] WAVE_CUBE_UP   = 3'd6;
  localparam logic [2:0] WAVE_CUBE_DOWN = 3'd7;

  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [15:0] LFSR_MASK   = 16'hB400;
  localparam logic [15:0] LFSR_SEED   = 16'hACE1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic       command;
    logic [7:0] voice_number;
  } lfo_in_t;

  typedef struct packed {
    logic [15:0] level;
    logic        phase_wrapped;
  } lfo_out_t;

  typedef struct packed {
    logic [31:0] phase_increment;
    logic [2:0]  wave_select;
    logic [7:0]  retrigger_voice;
    logic [31:0] start_phase;
  } lfo_cfg_t;

  typedef enum logic {
    JOB_TICK,
    JOB_TRIGGER
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
  } lfo_job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_SCALE,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

// File: hdl/lfo_front.sv
// ----------------------------------------------------------------------------
// lfo_front
// Accepts input items and classifies them; only ticks and matching triggers
// are queued for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfo_front (
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire lfo_pkg::lfo_in_t in_data,
  input  wire logic [7:0]      retrigger_voice,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output lfo_pkg::lfo_job_t    push_job
);
  import lfo_pkg::*;

  logic is_tick;
  logic is_match;

  assign is_tick  = (in_data.command == CMD_TICK);
  assign is_match = (in_data.voice_number == retrigger_voice);

  assign in_ready      = push_ready;
  assign push_valid    = in_valid && (is_tick || is_match);
  assign push_job.kind = is_tick ? JOB_TICK : JOB_TRIGGER;

endmodule

`default_nettype wire

// File: hdl/lfo_queue.sv
// ----------------------------------------------------------------------------
// lfo_queue
// Short FIFO of classified jobs between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfo_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire lfo_pkg::lfo_job_t push_job,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output lfo_pkg::lfo_job_t      pop_job
);
  import lfo_pkg::*;

  lfo_job_t            entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lfo_sine_rom.sv
// ----------------------------------------------------------------------------
// lfo_sine_rom
// Quarter-wave sine table, entries built from a fixed-point Taylor series,
// with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfo_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int LEVEL_BITS       = 16
) (
  input  wire logic                                clk,
  input  wire logic [$clog2(SINE_TABLE_DEPTH):0]   addr,
  output logic      [LEVEL_BITS-2:0]               data
);
  import lfo_pkg::*;

  localparam logic [63:0] HALF_AMP = (64'd1 << (LEVEL_BITS - 1)) - 64'd1;

  function automatic logic [LEVEL_BITS-2:0] sine_entry(input logic [31:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (64'(k) * 64'(HALF_PI_Q30)) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    v    = (sum * HALF_AMP + (64'd1 << 29)) >> 30;
    if (v > HALF_AMP) begin
      v = HALF_AMP;
    end
    return v[LEVEL_BITS-2:0];
  endfunction

  logic [LEVEL_BITS-2:0] rom_w [SINE_TABLE_DEPTH+1];
  logic [LEVEL_BITS-2:0] data_r;

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    assign rom_w[k] = sine_entry(32'(k));
  end

  always_ff @(posedge clk) begin
    data_r <= rom_w[addr];
  end

  assign data = data_r;

endmodule

`default_nettype wire

// File: hdl/lfo_back.sv
// ----------------------------------------------------------------------------
// lfo_back
// Executes queued jobs: phase update, LFSR, shared 32x32 multiplier for the
// cube waves, level scaling, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfo_back #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int LEVEL_BITS       = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lfo_pkg::lfo_cfg_t cfg,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire lfo_pkg::lfo_job_t job,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lfo_pkg::lfo_out_t      out_data
);
  import lfo_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int L  = LEVEL_BITS;
  localparam int NW = 16 + LEVEL_BITS + 1;

  back_state_t     state_r;
  back_state_t     state_nxt;

  logic [31:0]     acc_r;
  logic [15:0]     held_r;
  logic [15:0]     lfsr_r;
  logic [31:0]     p_r;
  logic            wrap_r;
  logic [31:0]     prod_r;
  logic [NW-1:0]   rq_r;
  logic [NW-1:0]   rr_r;
  logic [L-1:0]    lvl_r;
  logic [L-1:0]    lvl_nxt;

  logic            pop;
  logic [32:0]     sum33;
  logic [15:0]     lfsr_step;
  logic [31:0]     x_op;
  logic [31:0]     mul_a;
  logic [63:0]     mul_res;
  logic [NW-1:0]   rnd_num;
  logic [NW-1:0]   q1;
  logic [NW-1:0]   r1;
  logic [31:0]     tri_q;
  logic [31:0]     tri_r;
  logic [31:0]     scale_u;
  logic [31+L:0]   scale_ext;
  logic [L-1:0]    scaled;
  logic [AW-1:0]   rom_idx;
  logic [AW:0]     rom_addr;
  logic [L-2:0]    rom_data;
  logic [L-1:0]    sine_lvl;
  logic [L-1:0]    rnd_lvl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid && job.kind == JOB_TICK) begin
          state_nxt = B_MUL1;
        end
      end
      B_MUL1:  state_nxt = B_MUL2;
      B_MUL2:  state_nxt = B_SCALE;
      B_SCALE: state_nxt = B_DONE;
      B_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign pop       = job_valid && job_ready;
  assign sum33     = {1'b0, acc_r} + {1'b0, cfg.phase_increment};
  assign lfsr_step = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? LFSR_MASK : 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
      lfsr_r <= LFSR_SEED;
    end else if (pop) begin
      if (job.kind == JOB_TRIGGER) begin
        acc_r <= cfg.start_phase;
      end else begin
        acc_r <= sum33[31:0];
        if (cfg.wave_select == WAVE_RANDOM && sum33[32]) begin
          lfsr_r <= lfsr_step;
          held_r <= lfsr_step;
        end
      end
    end
  end

  // shared multiplier: x*x, then (x*x >> 32) * x
  assign x_op    = (cfg.wave_select == WAVE_CUBE_DOWN) ? ~p_r : p_r;
  assign mul_a   = (state_r == B_MUL1) ? x_op : prod_r;
  assign mul_res = 64'(mul_a) * 64'(x_op);

  // random level: (held * LMAX + 32767) / 65535 by folding 2^16 = 65535 + 1
  assign rnd_num = NW'({held_r, {L{1'b0}}}) - NW'(held_r) + NW'(32767);
  assign q1      = rr_r >> 16;
  assign r1      = NW'(rr_r[15:0]) + q1;
  assign rnd_lvl = L'(rq_r) + L'(rr_r >= NW'(65535));

  assign tri_q = p_r + 32'h4000_0000;
  assign tri_r = tri_q[31] ? ~tri_q : tri_q;

  always_comb begin
    unique case (cfg.wave_select)
      WAVE_TRIANGLE:               scale_u = {tri_r[30:0], 1'b0};
      WAVE_CUBE_UP, WAVE_CUBE_DOWN: scale_u = prod_r;
      default:                     scale_u = p_r;
    endcase
  end

  // (u * LMAX) >> 32 with LMAX = 2^L - 1
  assign scale_ext = {scale_u, {L{1'b0}}} - (32+L)'(scale_u);
  assign scaled    = scale_ext[31+L:32];

  assign rom_idx  = p_r[29:30-AW];
  assign rom_addr = p_r[30] ? ((AW+1)'(SINE_TABLE_DEPTH) - {1'b0, rom_idx})
                            : {1'b0, rom_idx};
  assign sine_lvl = p_r[31] ? {1'b0, ~rom_data} : {1'b1, rom_data};

  lfo_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .LEVEL_BITS      (LEVEL_BITS)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .data(rom_data)
  );

  always_comb begin
    unique case (cfg.wave_select)
      WAVE_SINE:      lvl_nxt = sine_lvl;
      WAVE_TRIANGLE:  lvl_nxt = scaled;
      WAVE_SAW_UP:    lvl_nxt = scaled;
      WAVE_SAW_DOWN:  lvl_nxt = ~scaled;
      WAVE_SQUARE:    lvl_nxt = p_r[31] ? '0 : '1;
      WAVE_RANDOM:    lvl_nxt = rnd_lvl;
      WAVE_CUBE_UP:   lvl_nxt = scaled;
      WAVE_CUBE_DOWN: lvl_nxt = scaled;
      default:        lvl_nxt = scaled;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && job.kind == JOB_TICK) begin
      p_r    <= sum33[31:0];
      wrap_r <= sum33[32];
    end
    if (state_r == B_MUL1) begin
      prod_r <= mul_res[63:32];
      rq_r   <= rnd_num >> 16;
      rr_r   <= NW'(rnd_num[15:0]) + (rnd_num >> 16);
    end
    if (state_r == B_MUL2) begin
      prod_r <= mul_res[63:32];
      rq_r   <= rq_r + q1;
      rr_r   <= r1;
    end
    if (state_r == B_SCALE) begin
      lvl_r <= lvl_nxt;
    end
  end

  assign out_data.level         = 16'(lvl_r);
  assign out_data.phase_wrapped = wrap_r;

endmodule

`default_nettype wire

// File: hdl/multi_waveform_lfo.sv
// ----------------------------------------------------------------------------
// multi_waveform_lfo
// Sequence: a tick passes through the queue, the phase add, two multiplier
// steps and scaling before its result is given; triggers give no result.
// A new tick enters the back end only once the last result is taken, set by
// the sequence around the shared multiplier; a trigger is done in B_IDLE.
// Reset (synchronous, active low): control, config, phase 0, LFSR seed 0xACE1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_waveform_lfo #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int LEVEL_BITS       = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire lfo_pkg::lfo_in_t                   in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output lfo_pkg::lfo_out_t                       out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lfo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lfo_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lfo_pkg::*;

  lfo_cfg_t cfg_r;
  logic     push_valid;
  logic     push_ready;
  lfo_job_t push_job;
  logic     job_valid;
  logic     job_ready;
  lfo_job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_INC:   cfg_r.phase_increment <= cfg_data;
        REG_WAVE_SELECT: cfg_r.wave_select     <= cfg_data[2:0];
        REG_RETRIG:      cfg_r.retrigger_voice <= cfg_data[7:0];
        REG_START_PHASE: cfg_r.start_phase     <= cfg_data;
        default: ;
      endcase
    end
  end

  lfo_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .retrigger_voice(cfg_r.retrigger_voice),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_job       (push_job)
  );

  lfo_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (job_valid),
    .pop_ready (job_ready),
    .pop_job   (job)
  );

  lfo_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .LEVEL_BITS      (LEVEL_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job      (job),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
